[rtl/core/gcfe_pkg.sv]
package gcfe_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 14;
    localparam int unsigned S_DATA_W   = 88;
    localparam int unsigned M_DATA_W   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_DEAD = 3'd0,
        REG_TRIGGER_MID  = 3'd1,
        REG_TRIGGER_HIGH = 3'd2,
        REG_DIST_LOW     = 3'd3,
        REG_DIST_MID     = 3'd4,
        REG_DIST_HIGH    = 3'd5
    } cfg_idx_t;

    localparam logic [7:0]  TRIGGER_DEAD_RST = 8'd5;
    localparam logic [7:0]  TRIGGER_MID_RST  = 8'd120;
    localparam logic [7:0]  TRIGGER_HIGH_RST = 8'd240;
    localparam logic [13:0] DIST_LOW_RST     = 14'd100;
    localparam logic [13:0] DIST_MID_RST     = 14'd3000;
    localparam logic [13:0] DIST_HIGH_RST    = 14'd6000;

    // x / 400 as (x * ceil(2^24 / 400)) >> 24, exact for |x| <= 32768
    localparam logic [15:0] DIV_RECIP = 16'd41944;
    localparam int unsigned DIV_SHIFT = 24;

    // index of the final byte in a frame
    localparam logic [1:0] LAST_NO_STEER = 2'd2;
    localparam logic [1:0] LAST_STEER    = 2'd3;

    typedef struct packed {
        logic [7:0]  trigger_dead;
        logic [7:0]  trigger_mid;
        logic [7:0]  trigger_high;
        logic [13:0] dist_low;
        logic [13:0] dist_mid;
        logic [13:0] dist_high;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
        logic               fire_button;
        logic               reverse_button;
        logic               strut_fwd_button;
        logic               strut_rev_button;
    } snap_t;

    typedef struct packed {
        logic signed [7:0] lx;
        logic signed [7:0] ly;
        logic signed [7:0] rx;
        logic signed [7:0] ry;
        logic [7:0]        lt;
        logic [7:0]        rt;
        logic              fire;
        logic              rev;
        logic              sfw;
        logic              srv;
    } quot_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            rumble;
    } frame_t;

endpackage

[rtl/core/gcfe_div.sv]
module gcfe_div
    import gcfe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  snap_t in_snap,
    output logic  out_valid,
    input  logic  out_ready,
    output quot_t out_quot
);

    logic  valid_reg;
    snap_t snap_reg;

    function automatic logic signed [7:0] div400(input logic signed [15:0] x);
        logic [15:0] mag;
        logic [31:0] prod;
        logic [7:0]  q;
        mag  = x[15] ? 16'(-x) : 16'(x);
        prod = 32'(mag) * 32'(DIV_RECIP);
        q    = {1'b0, prod[DIV_SHIFT+6:DIV_SHIFT]};
        return x[15] ? signed'(8'(-q)) : signed'(q);
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            snap_reg <= in_snap;
        end
    end

    always_comb
    begin
        out_quot.lx   = div400(snap_reg.left_x);
        out_quot.ly   = div400(snap_reg.left_y);
        out_quot.rx   = div400(snap_reg.right_x);
        out_quot.ry   = div400(snap_reg.right_y);
        out_quot.lt   = snap_reg.left_trigger;
        out_quot.rt   = snap_reg.right_trigger;
        out_quot.fire = snap_reg.fire_button;
        out_quot.rev  = snap_reg.reverse_button;
        out_quot.sfw  = snap_reg.strut_fwd_button;
        out_quot.srv  = snap_reg.strut_rev_button;
    end

endmodule

[rtl/core/gcfe_enc.sv]
module gcfe_enc
    import gcfe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  quot_t  in_quot,
    output logic   out_valid,
    input  logic   out_ready,
    output frame_t out_frame
);

    logic  valid_reg;
    quot_t q_reg;

    logic signed [15:0] sqx;
    logic signed [15:0] sqy;
    logic [13:0]        dist_sq;
    logic [6:0]         ax;
    logic               lx_pos;
    logic               ly_pos;
    logic               lrel;
    logic               rrel;
    logic               lpress;
    logic               rpress;
    logic [1:0]         lt_lvl;
    logic [1:0]         rt_lvl;
    logic signed [3:0]  vx;
    logic signed [3:0]  vy;
    logic signed [3:0]  lu;
    logic signed [3:0]  ld;
    logic signed [3:0]  ru;
    logic signed [3:0]  rd;
    logic [1:0]         sx_mag;
    logic [1:0]         sy_mag;
    logic [7:0]         btn;

    function automatic logic signed [3:0] sgn_lvl(input logic pos, input logic [1:0] mag);
        logic signed [3:0] m;
        m = signed'({2'b00, mag});
        return pos ? m : -m;
    endfunction

    // direction bit (set when positive) above a 2-bit magnitude
    function automatic logic [2:0] pack_wheel(input logic signed [3:0] v);
        logic [3:0] a;
        a = v[3] ? 4'(-v) : 4'(v);
        return {(v > 4'sd0), a[1:0]};
    endfunction

    function automatic logic [1:0] trig_lvl(input logic [7:0] t, input cfg_t c);
        logic [1:0] r;
        if (t > c.trigger_high)
        begin
            r = 2'd3;
        end
        else if (t > c.trigger_mid)
        begin
            r = 2'd2;
        end
        else
        begin
            r = 2'd1;
        end
        return r;
    endfunction

    function automatic logic [1:0] steer_mag(input logic signed [7:0] p);
        logic [6:0] a;
        logic [1:0] m;
        a = p[7] ? 7'(-p) : 7'(p);
        if (a > 7'd75)
        begin
            m = 2'd3;
        end
        else if (a > 7'd40)
        begin
            m = 2'd2;
        end
        else if (a > 7'd15)
        begin
            m = 2'd1;
        end
        else
        begin
            m = 2'd0;
        end
        return m;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            q_reg <= in_quot;
        end
    end

    assign sqx     = q_reg.lx * q_reg.lx;
    assign sqy     = q_reg.ly * q_reg.ly;
    assign dist_sq = sqx[13:0] + sqy[13:0];
    assign ax      = q_reg.lx[7] ? 7'(-q_reg.lx) : 7'(q_reg.lx);
    assign lx_pos  = q_reg.lx > 8'sd0;
    assign ly_pos  = q_reg.ly > 8'sd0;
    assign lrel    = q_reg.lt < cfg.trigger_dead;
    assign rrel    = q_reg.rt < cfg.trigger_dead;
    assign lpress  = q_reg.lt > cfg.trigger_dead;
    assign rpress  = q_reg.rt > cfg.trigger_dead;
    assign lt_lvl  = trig_lvl(q_reg.lt, cfg);
    assign rt_lvl  = trig_lvl(q_reg.rt, cfg);

    always_comb
    begin
        vx = 4'sd0;
        vy = 4'sd0;
        priority if (ax > 7'd75)
        begin
            vx = sgn_lvl(lx_pos, 2'd3);
        end
        else if (ax > 7'd40)
        begin
            vx = sgn_lvl(lx_pos, 2'd2);
            if (dist_sq > cfg.dist_high)
            begin
                vy = sgn_lvl(ly_pos, 2'd1);
            end
        end
        else if (ax > 7'd25)
        begin
            vx = sgn_lvl(lx_pos, 2'd1);
            if (dist_sq > cfg.dist_high)
            begin
                vy = sgn_lvl(ly_pos, 2'd2);
            end
            else if (dist_sq > cfg.dist_mid)
            begin
                vy = sgn_lvl(ly_pos, 2'd1);
            end
        end
        else
        begin
            if (dist_sq > cfg.dist_high)
            begin
                vy = sgn_lvl(ly_pos, 2'd3);
            end
            else if (dist_sq > cfg.dist_mid)
            begin
                vy = sgn_lvl(ly_pos, 2'd2);
            end
            else if (dist_sq > cfg.dist_low)
            begin
                vy = sgn_lvl(ly_pos, 2'd1);
            end
        end
    end

    always_comb
    begin
        lu = 4'sd0;
        ld = 4'sd0;
        ru = 4'sd0;
        rd = 4'sd0;
        // both released: drive from the stick; both pressed, or a trigger sitting exactly on the dead value: stop
        if (lrel && rrel)
        begin
            ru = vx + vy;
            ld = vx + vy;
            lu = vy - vx;
            rd = vy - vx;
        end
        else if (lpress && rrel)
        begin
            lu = sgn_lvl(1'b1, lt_lvl);
            ld = sgn_lvl(1'b1, lt_lvl);
            ru = sgn_lvl(1'b0, lt_lvl);
            rd = sgn_lvl(1'b0, lt_lvl);
        end
        else if (lrel && rpress)
        begin
            lu = sgn_lvl(1'b0, rt_lvl);
            ld = sgn_lvl(1'b0, rt_lvl);
            ru = sgn_lvl(1'b1, rt_lvl);
            rd = sgn_lvl(1'b1, rt_lvl);
        end
    end

    assign sx_mag = steer_mag(q_reg.rx);
    assign sy_mag = steer_mag(q_reg.ry);

    // weights 48, 32, 12 and 8 on a base of 64; they may overlap
    assign btn = 8'd64 + (q_reg.fire ? 8'd48 : 8'd0) + (q_reg.rev ? 8'd32 : 8'd0)
               + (q_reg.sfw ? 8'd12 : 8'd0) + (q_reg.srv ? 8'd8 : 8'd0);

    always_comb
    begin
        out_frame.bytes[0] = {2'b10, pack_wheel(lu), pack_wheel(ld)};
        out_frame.bytes[1] = {2'b11, pack_wheel(ru), pack_wheel(rd)};
        out_frame.bytes[2] = btn;
        out_frame.bytes[3] = {2'b00, (sx_mag != 2'd0) && !q_reg.rx[7], sx_mag,
                              (sy_mag != 2'd0) && !q_reg.ry[7], sy_mag};
        out_frame.last_idx = ((sx_mag != 2'd0) || (sy_mag != 2'd0)) ? LAST_STEER
                                                                    : LAST_NO_STEER;
        out_frame.rumble   = q_reg.fire;
    end

endmodule

[rtl/core/gcfe_ser.sv]
module gcfe_ser
    import gcfe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  frame_t in_frame,
    output logic   out_valid,
    input  logic   out_ready,
    output logic [7:0] out_byte,
    output logic   out_last,
    output logic   out_rumble
);

    logic       valid_reg;
    logic [1:0] idx_reg;
    frame_t     frame_reg;
    logic       take;
    logic       finish;
    logic       load;

    assign out_valid  = valid_reg;
    assign out_byte   = frame_reg.bytes[idx_reg];
    assign out_last   = idx_reg == frame_reg.last_idx;
    assign out_rumble = frame_reg.rumble;

    assign take     = valid_reg && out_ready;
    assign finish   = take && out_last;
    // next frame loads as the last word of the current one leaves
    assign in_ready = !valid_reg || finish;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (finish)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= in_frame;
        end
    end

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> idx_reg <= frame_reg.last_idx)
        else $error("word index past end of frame");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !out_last) |=> (valid_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("word index did not advance");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && !in_valid) |=> !valid_reg)
        else $error("frame still valid after its last word");

    a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (valid_reg && idx_reg == 2'd0))
        else $error("new frame did not start at its first word");

endmodule

[rtl/core/gamepad_command_frame_encoder.sv]
// Gamepad command frame encoder.
//
// Slave stream: one gamepad snapshot per word. Master stream: the command
// bytes of each snapshot, one per word: motor byte 1, motor byte 2, button
// byte, then a steering byte only when the right stick leaves its centre.
// m_axis_tlast marks the final byte of a snapshot; m_axis_tuser carries the
// rumble flag, the same on every byte of the snapshot.
// Configuration: cfg_we writes cfg_data to the register cfg_index in the
// same edge; indexes beyond the last register are ignored.
//
// Pipeline: the first byte is presented once the snapshot has passed the
// quotient register and then the frame register. The frame register then
// sends one byte per cycle while m_axis_tready is high, so a snapshot
// occupies the output for three or four bytes; that serialiser sets the
// sustained rate. Two snapshots can wait in the earlier stages, and a new
// one is taken every cycle there is room.
// Reset clears all valid flags and loads the default thresholds. When the
// receiver holds m_axis_tready low the current byte holds, and the stages
// behind fill and then drop s_axis_tready.
module gamepad_command_frame_encoder
    import gcfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // left_x[15:0], left_y[31:16], right_x[47:32], right_y[63:48],
    // left_trigger[71:64], right_trigger[79:72], fire_button[80],
    // reverse_button[81], strut_fwd_button[82], strut_rev_button[83], zero
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // frame_byte[7:0]
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    output logic                  m_axis_tlast,
    // rumble[0]
    output logic                  m_axis_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t   cfg_reg;
    snap_t  snap;
    quot_t  quot;
    frame_t frame;
    logic   div_valid;
    logic   div_ready;
    logic   enc_valid;
    logic   enc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_dead <= TRIGGER_DEAD_RST;
            cfg_reg.trigger_mid  <= TRIGGER_MID_RST;
            cfg_reg.trigger_high <= TRIGGER_HIGH_RST;
            cfg_reg.dist_low     <= DIST_LOW_RST;
            cfg_reg.dist_mid     <= DIST_MID_RST;
            cfg_reg.dist_high    <= DIST_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TRIGGER_DEAD: cfg_reg.trigger_dead <= cfg_data[7:0];
                REG_TRIGGER_MID:  cfg_reg.trigger_mid  <= cfg_data[7:0];
                REG_TRIGGER_HIGH: cfg_reg.trigger_high <= cfg_data[7:0];
                REG_DIST_LOW:     cfg_reg.dist_low     <= cfg_data;
                REG_DIST_MID:     cfg_reg.dist_mid     <= cfg_data;
                REG_DIST_HIGH:    cfg_reg.dist_high    <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        snap.left_x           = signed'(s_axis_tdata[15:0]);
        snap.left_y           = signed'(s_axis_tdata[31:16]);
        snap.right_x          = signed'(s_axis_tdata[47:32]);
        snap.right_y          = signed'(s_axis_tdata[63:48]);
        snap.left_trigger     = s_axis_tdata[71:64];
        snap.right_trigger    = s_axis_tdata[79:72];
        snap.fire_button      = s_axis_tdata[80];
        snap.reverse_button   = s_axis_tdata[81];
        snap.strut_fwd_button = s_axis_tdata[82];
        snap.strut_rev_button = s_axis_tdata[83];
    end

    gcfe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_snap   (snap),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_quot  (quot)
    );

    gcfe_enc u_enc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_quot   (quot),
        .out_valid (enc_valid),
        .out_ready (enc_ready),
        .out_frame (frame)
    );

    gcfe_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (enc_valid),
        .in_ready   (enc_ready),
        .in_frame   (frame),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_rumble (m_axis_tuser)
    );

endmodule
